// ----- hw/rtl/cpc_pkg.sv -----
// Shared types and constants of the circle pair collision response pipeline.
`default_nettype none
package cpc_pkg;

	localparam int SQ_STEPS  = 25;
	localparam int DIV_STEPS = 17;
	localparam int SQ_BASE   = 3;
	localparam int DIV_BASE  = SQ_BASE + SQ_STEPS + 2;
	localparam int BK_BASE   = DIV_BASE + DIV_STEPS;
	localparam int NSTG      = BK_BASE + 5;

	localparam logic [15:0] GAIN_RST = 16'd34406;
	localparam int POS_MAX = 262143;
	localparam int VEL_MAX = 524287;
	localparam int VEL_MIN = -524288;

	typedef struct packed {
		logic [17:0] p1x;
		logic [17:0] p1y;
		logic [17:0] p2x;
		logic [17:0] p2y;
		logic [19:0] v1x;
		logic [19:0] v1y;
		logic [19:0] v2x;
		logic [19:0] v2y;
		logic [20:0] dvx;
		logic [20:0] dvy;
		logic        sx;
		logic        sy;
		logic [17:0] dxm;
		logic [17:0] dym;
		logic [16:0] rs;
		logic        hit;
		logic [24:0] m;
	} side_t;

	typedef struct packed {
		logic [NSTG-1:0] en;
		logic [NSTG-1:0] vld;
	} pipe_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/circle_pair_collision_response_top.sv -----
// Top level of the circle pair collision response pipeline.
//
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_ready    first_*, second_* circle fields
//  out       source     out_valid / out_ready  hit, new_* fields
//  cfg       sink       cfg_wr_en              cfg_wr_data (separation gain)
//
// The pipeline has 3 front stages, 25 square-root stages (one root bit each),
// 2 setup stages, 17 divider stages (one quotient bit each), 5 back stages.
// One item enters per cycle while in_ready is high. A stall at the output holds the
// last stage and empty stages behind it keep filling. Reset clears all valid bits
// and loads the gain with 0.525.
`default_nettype none
module circle_pair_collision_response_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [17:0]        first_pos_x,
	input  wire logic [17:0]        first_pos_y,
	input  wire logic signed [19:0] first_vel_x,
	input  wire logic signed [19:0] first_vel_y,
	input  wire logic [15:0]        first_radius,
	input  wire logic [17:0]        second_pos_x,
	input  wire logic [17:0]        second_pos_y,
	input  wire logic signed [19:0] second_vel_x,
	input  wire logic signed [19:0] second_vel_y,
	input  wire logic [15:0]        second_radius,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    hit,
	output logic [17:0]             new_first_pos_x,
	output logic [17:0]             new_first_pos_y,
	output logic [17:0]             new_second_pos_x,
	output logic [17:0]             new_second_pos_y,
	output logic signed [19:0]      new_first_vel_x,
	output logic signed [19:0]      new_first_vel_y,
	output logic signed [19:0]      new_second_vel_x,
	output logic signed [19:0]      new_second_vel_y,
	input  wire logic               cfg_wr_en,
	input  wire logic [15:0]        cfg_wr_data
);

	function automatic logic [17:0] pos_upd(input logic [17:0] p, input logic [17:0] dm,
		input logic neg);
		logic signed [19:0] s;
		s = neg ? $signed({2'b0, p}) - $signed({2'b0, dm})
		        : $signed({2'b0, p}) + $signed({2'b0, dm});
		if (s < 0)
			return '0;
		else if (s > cpc_pkg::POS_MAX)
			return 18'(cpc_pkg::POS_MAX);
		else
			return s[17:0];
	endfunction

	function automatic logic [19:0] vel_upd(input logic [19:0] v, input logic [23:0] cm,
		input logic neg);
		logic signed [25:0] s;
		s = neg ? $signed({{6{v[19]}}, v}) - $signed({2'b0, cm})
		        : $signed({{6{v[19]}}, v}) + $signed({2'b0, cm});
		if (s < cpc_pkg::VEL_MIN)
			return 20'(cpc_pkg::VEL_MIN);
		else if (s > cpc_pkg::VEL_MAX)
			return 20'(cpc_pkg::VEL_MAX);
		else
			return s[19:0];
	endfunction

	cpc_pkg::pipe_ctl_t ctl;
	logic [15:0]        gain_q;

	cpc_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_ready (out_ready),
		.in_ready  (in_ready),
		.ctl       (ctl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			gain_q <= cpc_pkg::GAIN_RST;
		else if (cfg_wr_en)
			gain_q <= cfg_wr_data;
	end

	// S1: differences and radius sum
	logic [18:0]    dxs;
	logic [18:0]    dys;
	cpc_pkg::side_t side_s1;

	assign dxs = {1'b0, first_pos_x} - {1'b0, second_pos_x};
	assign dys = {1'b0, first_pos_y} - {1'b0, second_pos_y};

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			side_s1.p1x <= first_pos_x;
			side_s1.p1y <= first_pos_y;
			side_s1.p2x <= second_pos_x;
			side_s1.p2y <= second_pos_y;
			side_s1.v1x <= first_vel_x;
			side_s1.v1y <= first_vel_y;
			side_s1.v2x <= second_vel_x;
			side_s1.v2y <= second_vel_y;
			side_s1.dvx <= {second_vel_x[19], second_vel_x} - {first_vel_x[19], first_vel_x};
			side_s1.dvy <= {second_vel_y[19], second_vel_y} - {first_vel_y[19], first_vel_y};
			side_s1.sx  <= dxs[18];
			side_s1.sy  <= dys[18];
			side_s1.dxm <= dxs[18] ? 18'(-dxs) : dxs[17:0];
			side_s1.dym <= dys[18] ? 18'(-dys) : dys[17:0];
			side_s1.rs  <= {1'b0, first_radius} + {1'b0, second_radius};
			side_s1.hit <= 1'b0;
			side_s1.m   <= '0;
		end
	end

	// S2: squares
	logic [35:0]    dx2_s2;
	logic [35:0]    dy2_s2;
	logic [33:0]    rs2_s2;
	cpc_pkg::side_t side_s2;

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			dx2_s2  <= side_s1.dxm * side_s1.dxm;
			dy2_s2  <= side_s1.dym * side_s1.dym;
			rs2_s2  <= side_s1.rs * side_s1.rs;
			side_s2 <= side_s1;
		end
	end

	// S3: distance test, radicand
	logic [36:0]    d2;
	logic [49:0]    rad_s3;
	cpc_pkg::side_t s3_nxt;
	cpc_pkg::side_t side_s3;

	assign d2 = {1'b0, dx2_s2} + {1'b0, dy2_s2};

	always_comb begin
		s3_nxt     = side_s2;
		s3_nxt.hit = (d2 != '0) && (d2 < {3'b0, rs2_s2});
	end

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			rad_s3  <= {d2[33:0], 16'b0};
			side_s3 <= s3_nxt;
		end
	end

	// square root
	logic [49:0]    sq_rem  [0:cpc_pkg::SQ_STEPS];
	logic [24:0]    sq_root [0:cpc_pkg::SQ_STEPS];
	cpc_pkg::side_t sq_side [0:cpc_pkg::SQ_STEPS];

	assign sq_rem[0]  = rad_s3;
	assign sq_root[0] = '0;
	assign sq_side[0] = side_s3;

	for (genvar j = 0; j < cpc_pkg::SQ_STEPS; j++) begin : g_sq
		cpc_sqrt_step #(.BIT(cpc_pkg::SQ_STEPS - 1 - j)) u_step (
			.clk    (clk),
			.en     (ctl.en[cpc_pkg::SQ_BASE + j]),
			.rem_i  (sq_rem[j]),
			.root_i (sq_root[j]),
			.side_i (sq_side[j]),
			.rem_o  (sq_rem[j+1]),
			.root_o (sq_root[j+1]),
			.side_o (sq_side[j+1])
		);
	end

	// P1: overlap
	logic [24:0]    d_p1;
	cpc_pkg::side_t p1_nxt;
	cpc_pkg::side_t side_p1;

	always_comb begin
		p1_nxt   = sq_side[cpc_pkg::SQ_STEPS];
		p1_nxt.m = {sq_side[cpc_pkg::SQ_STEPS].rs, 8'b0} - sq_root[cpc_pkg::SQ_STEPS];
	end

	always_ff @(posedge clk) begin
		if (ctl.en[cpc_pkg::SQ_BASE + cpc_pkg::SQ_STEPS]) begin
			d_p1    <= sq_root[cpc_pkg::SQ_STEPS];
			side_p1 <= p1_nxt;
		end
	end

	// P2: push magnitude, divider setup
	logic [40:0]    mprod;
	logic [24:0]    d_p2;
	logic [41:0]    rx_p2;
	logic [41:0]    ry_p2;
	cpc_pkg::side_t p2_nxt;
	cpc_pkg::side_t side_p2;

	assign mprod = side_p1.m * gain_q;

	always_comb begin
		p2_nxt   = side_p1;
		p2_nxt.m = mprod[40:16];
	end

	always_ff @(posedge clk) begin
		if (ctl.en[cpc_pkg::SQ_BASE + cpc_pkg::SQ_STEPS + 1]) begin
			d_p2    <= d_p1;
			rx_p2   <= {side_p1.dxm, 24'b0};
			ry_p2   <= {side_p1.dym, 24'b0};
			side_p2 <= p2_nxt;
		end
	end

	// unit normal dividers
	logic [41:0]    dv_rx   [0:cpc_pkg::DIV_STEPS];
	logic [41:0]    dv_ry   [0:cpc_pkg::DIV_STEPS];
	logic [16:0]    dv_qx   [0:cpc_pkg::DIV_STEPS];
	logic [16:0]    dv_qy   [0:cpc_pkg::DIV_STEPS];
	logic [24:0]    dv_d    [0:cpc_pkg::DIV_STEPS];
	cpc_pkg::side_t dv_side [0:cpc_pkg::DIV_STEPS];

	assign dv_rx[0]   = rx_p2;
	assign dv_ry[0]   = ry_p2;
	assign dv_qx[0]   = '0;
	assign dv_qy[0]   = '0;
	assign dv_d[0]    = d_p2;
	assign dv_side[0] = side_p2;

	for (genvar j = 0; j < cpc_pkg::DIV_STEPS; j++) begin : g_div
		cpc_div_step #(.BIT(cpc_pkg::DIV_STEPS - 1 - j)) u_step (
			.clk    (clk),
			.en     (ctl.en[cpc_pkg::DIV_BASE + j]),
			.rx_i   (dv_rx[j]),
			.ry_i   (dv_ry[j]),
			.qx_i   (dv_qx[j]),
			.qy_i   (dv_qy[j]),
			.d_i    (dv_d[j]),
			.side_i (dv_side[j]),
			.rx_o   (dv_rx[j+1]),
			.ry_o   (dv_ry[j+1]),
			.qx_o   (dv_qx[j+1]),
			.qy_o   (dv_qy[j+1]),
			.d_o    (dv_d[j+1]),
			.side_o (dv_side[j+1])
		);
	end

	// B1: push products, dot product terms
	cpc_pkg::side_t     dvs;
	logic [16:0]        qxf;
	logic [16:0]        qyf;
	logic signed [17:0] nx;
	logic signed [17:0] ny;
	logic [41:0]        pmx_b1;
	logic [41:0]        pmy_b1;
	logic signed [38:0] ex_b1;
	logic signed [38:0] ey_b1;
	logic [16:0]        qx_b1;
	logic [16:0]        qy_b1;
	cpc_pkg::side_t     side_b1;

	assign dvs = dv_side[cpc_pkg::DIV_STEPS];
	assign qxf = dv_qx[cpc_pkg::DIV_STEPS];
	assign qyf = dv_qy[cpc_pkg::DIV_STEPS];
	assign nx  = dvs.sx ? -$signed({1'b0, qxf}) : $signed({1'b0, qxf});
	assign ny  = dvs.sy ? -$signed({1'b0, qyf}) : $signed({1'b0, qyf});

	always_ff @(posedge clk) begin
		if (ctl.en[cpc_pkg::BK_BASE]) begin
			pmx_b1  <= dvs.m * qxf;
			pmy_b1  <= dvs.m * qyf;
			ex_b1   <= $signed(dvs.dvx) * nx;
			ey_b1   <= $signed(dvs.dvy) * ny;
			qx_b1   <= qxf;
			qy_b1   <= qyf;
			side_b1 <= dvs;
		end
	end

	// B2: rounded push, closing speed
	logic [41:0]        pmx_r;
	logic [41:0]        pmy_r;
	logic [17:0]        pxm_b2;
	logic [17:0]        pym_b2;
	logic signed [39:0] vi_b2;
	logic [16:0]        qx_b2;
	logic [16:0]        qy_b2;
	cpc_pkg::side_t     side_b2;

	assign pmx_r = pmx_b1 + 42'h800000;
	assign pmy_r = pmy_b1 + 42'h800000;

	always_ff @(posedge clk) begin
		if (ctl.en[cpc_pkg::BK_BASE + 1]) begin
			pxm_b2  <= pmx_r[41:24];
			pym_b2  <= pmy_r[41:24];
			vi_b2   <= {ex_b1[38], ex_b1} + {ey_b1[38], ey_b1};
			qx_b2   <= qx_b1;
			qy_b2   <= qy_b1;
			side_b2 <= side_b1;
		end
	end

	// B3: positions, velocity change partial products
	logic [36:0]    lox_b3;
	logic [36:0]    loy_b3;
	logic [35:0]    hix_b3;
	logic [35:0]    hiy_b3;
	logic           vneg_b3;
	cpc_pkg::side_t b3_nxt;
	cpc_pkg::side_t side_b3;

	always_comb begin
		b3_nxt = side_b2;
		if (side_b2.hit) begin
			b3_nxt.p1x = pos_upd(side_b2.p1x, pxm_b2, side_b2.sx);
			b3_nxt.p1y = pos_upd(side_b2.p1y, pym_b2, side_b2.sy);
			b3_nxt.p2x = pos_upd(side_b2.p2x, pxm_b2, !side_b2.sx);
			b3_nxt.p2y = pos_upd(side_b2.p2y, pym_b2, !side_b2.sy);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[cpc_pkg::BK_BASE + 2]) begin
			lox_b3  <= vi_b2[19:0] * qx_b2;
			loy_b3  <= vi_b2[19:0] * qy_b2;
			hix_b3  <= vi_b2[38:20] * qx_b2;
			hiy_b3  <= vi_b2[38:20] * qy_b2;
			vneg_b3 <= vi_b2[39];
			side_b3 <= b3_nxt;
		end
	end

	// B4: rounded velocity change
	logic [55:0]    fx;
	logic [55:0]    fy;
	logic [23:0]    cxm_b4;
	logic [23:0]    cym_b4;
	logic           vneg_b4;
	cpc_pkg::side_t side_b4;

	assign fx = {hix_b3, 20'b0} + {19'b0, lox_b3} + 56'h80000000;
	assign fy = {hiy_b3, 20'b0} + {19'b0, loy_b3} + 56'h80000000;

	always_ff @(posedge clk) begin
		if (ctl.en[cpc_pkg::BK_BASE + 3]) begin
			cxm_b4  <= fx[55:32];
			cym_b4  <= fy[55:32];
			vneg_b4 <= vneg_b3;
			side_b4 <= side_b3;
		end
	end

	// B5: velocity exchange, output register
	cpc_pkg::side_t b5_nxt;
	cpc_pkg::side_t side_b5;

	always_comb begin
		b5_nxt = side_b4;
		if (side_b4.hit && !vneg_b4) begin
			b5_nxt.v1x = vel_upd(side_b4.v1x, cxm_b4, side_b4.sx);
			b5_nxt.v1y = vel_upd(side_b4.v1y, cym_b4, side_b4.sy);
			b5_nxt.v2x = vel_upd(side_b4.v2x, cxm_b4, !side_b4.sx);
			b5_nxt.v2y = vel_upd(side_b4.v2y, cym_b4, !side_b4.sy);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[cpc_pkg::BK_BASE + 4])
			side_b5 <= b5_nxt;
	end

	assign out_valid        = ctl.vld[cpc_pkg::NSTG-1];
	assign hit              = side_b5.hit;
	assign new_first_pos_x  = side_b5.p1x;
	assign new_first_pos_y  = side_b5.p1y;
	assign new_second_pos_x = side_b5.p2x;
	assign new_second_pos_y = side_b5.p2y;
	assign new_first_vel_x  = side_b5.v1x;
	assign new_first_vel_y  = side_b5.v1y;
	assign new_second_vel_x = side_b5.v2x;
	assign new_second_vel_y = side_b5.v2y;

endmodule
`default_nettype wire

// ----- hw/rtl/cpc_pipe_ctrl.sv -----
// Valid bits and per-stage load enables of the pipeline.
`default_nettype none
module cpc_pipe_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              out_ready,
	output logic                   in_ready,
	output cpc_pkg::pipe_ctl_t     ctl
);

	logic [cpc_pkg::NSTG-1:0] vld_q;
	logic [cpc_pkg::NSTG:0]   rdy;

	assign rdy[cpc_pkg::NSTG] = out_ready;

	for (genvar i = 0; i < cpc_pkg::NSTG; i++) begin : g_rdy
		assign rdy[i] = !vld_q[i] || rdy[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0])
				vld_q[0] <= in_valid;
			for (int i = 1; i < cpc_pkg::NSTG; i++) begin
				if (rdy[i])
					vld_q[i] <= vld_q[i-1];
			end
		end
	end

	assign in_ready = rdy[0];
	assign ctl.en   = rdy[cpc_pkg::NSTG-1:0];
	assign ctl.vld  = vld_q;

endmodule
`default_nettype wire

// ----- hw/rtl/cpc_sqrt_step.sv -----
// One stage of the restoring square root: decides one root bit.
`default_nettype none
module cpc_sqrt_step #(
	parameter int BIT = 24
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [49:0]   rem_i,
	input  wire logic [24:0]   root_i,
	input  wire cpc_pkg::side_t side_i,
	output logic [49:0]        rem_o,
	output logic [24:0]        root_o,
	output cpc_pkg::side_t     side_o
);

	logic [50:0]    trial;
	logic           ge;
	logic [49:0]    rem_s1;
	logic [24:0]    root_s1;
	cpc_pkg::side_t side_s1;

	// lower root bits are still zero, so OR is the add
	assign trial = ({26'b0, root_i} << (BIT + 1)) | (51'b1 << (2 * BIT));
	assign ge    = {1'b0, rem_i} >= trial;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= ge ? rem_i - trial[49:0] : rem_i;
			root_s1 <= ge ? (root_i | (25'b1 << BIT)) : root_i;
			side_s1 <= side_i;
		end
	end

	assign rem_o  = rem_s1;
	assign root_o = root_s1;
	assign side_o = side_s1;

endmodule
`default_nettype wire

// ----- hw/rtl/cpc_div_step.sv -----
// One stage of the two restoring dividers: one quotient bit per lane.
`default_nettype none
module cpc_div_step #(
	parameter int BIT = 16
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [41:0]   rx_i,
	input  wire logic [41:0]   ry_i,
	input  wire logic [16:0]   qx_i,
	input  wire logic [16:0]   qy_i,
	input  wire logic [24:0]   d_i,
	input  wire cpc_pkg::side_t side_i,
	output logic [41:0]        rx_o,
	output logic [41:0]        ry_o,
	output logic [16:0]        qx_o,
	output logic [16:0]        qy_o,
	output logic [24:0]        d_o,
	output cpc_pkg::side_t     side_o
);

	logic [42:0]    dsh;
	logic           gx;
	logic           gy;
	logic [41:0]    rx_s1;
	logic [41:0]    ry_s1;
	logic [16:0]    qx_s1;
	logic [16:0]    qy_s1;
	logic [24:0]    d_s1;
	cpc_pkg::side_t side_s1;

	assign dsh = {18'b0, d_i} << BIT;
	assign gx  = {1'b0, rx_i} >= dsh;
	assign gy  = {1'b0, ry_i} >= dsh;

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s1   <= gx ? rx_i - dsh[41:0] : rx_i;
			ry_s1   <= gy ? ry_i - dsh[41:0] : ry_i;
			qx_s1   <= gx ? (qx_i | (17'b1 << BIT)) : qx_i;
			qy_s1   <= gy ? (qy_i | (17'b1 << BIT)) : qy_i;
			d_s1    <= d_i;
			side_s1 <= side_i;
		end
	end

	assign rx_o   = rx_s1;
	assign ry_o   = ry_s1;
	assign qx_o   = qx_s1;
	assign qy_o   = qy_s1;
	assign d_o    = d_s1;
	assign side_o = side_s1;

endmodule
`default_nettype wire

// ----- hw/rtl/cpc_checker.sv -----
// Port-level checks of the collision response pipeline and their binding.
`default_nettype none
module cpc_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic               hit,
	input wire logic [17:0]        new_first_pos_x,
	input wire logic [17:0]        new_second_pos_x,
	input wire logic signed [19:0] new_first_vel_x,
	input wire logic signed [19:0] new_second_vel_x
);

	localparam int CW = $clog2(cpc_pkg::NSTG + 1);

	logic [CW-1:0] cnt_q;
	logic          in_acc;
	logic          out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (in_acc && !out_acc)
			cnt_q <= cnt_q + 1'b1;
		else if (out_acc && !in_acc)
			cnt_q <= cnt_q - 1'b1;
	end

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled while output is free");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cnt_q != '0))
		else $error("result shown with no item in flight");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(cpc_pkg::NSTG))
		else $error("more items in flight than stages");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit)
			&& $stable(new_first_pos_x) && $stable(new_second_pos_x)
			&& $stable(new_first_vel_x) && $stable(new_second_vel_x))
		else $error("stalled result changed");

endmodule

bind circle_pair_collision_response_top cpc_checker u_cpc_checker (.*);
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the circle pair collision response pipeline.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

	typedef struct packed {
		logic [17:0] p1x, p1y;
		logic signed [19:0] v1x, v1y;
		logic [15:0] r1;
		logic [17:0] p2x, p2y;
		logic signed [19:0] v2x, v2y;
		logic [15:0] r2;
	} pair_t;

	typedef struct packed {
		logic hit;
		logic [17:0] p1x, p1y, p2x, p2y;
		logic [19:0] v1x, v1y, v2x, v2y;
	} resp_t;

	localparam int WATCHDOG = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	pair_t drv = '0;
	logic out_valid;
	logic out_ready = 0;
	resp_t got;
	logic cfg_wr_en = 0;
	logic [15:0] cfg_wr_data = '0;

	logic [15:0] gain_q = cpc_pkg::GAIN_RST;
	resp_t expected_resp[$];
	int errors = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit no_idle = 0;

	always #5 clk = ~clk;

	circle_pair_collision_response_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.first_pos_x(drv.p1x), .first_pos_y(drv.p1y),
		.first_vel_x(drv.v1x), .first_vel_y(drv.v1y), .first_radius(drv.r1),
		.second_pos_x(drv.p2x), .second_pos_y(drv.p2y),
		.second_vel_x(drv.v2x), .second_vel_y(drv.v2y), .second_radius(drv.r2),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(got.hit),
		.new_first_pos_x(got.p1x), .new_first_pos_y(got.p1y),
		.new_second_pos_x(got.p2x), .new_second_pos_y(got.p2y),
		.new_first_vel_x(got.v1x), .new_first_vel_y(got.v1y),
		.new_second_vel_x(got.v2x), .new_second_vel_y(got.v2y),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	function automatic longint rnd_half(longint x, int s);
		longint m;
		m = ((x < 0 ? -x : x) + (longint'(1) <<< (s - 1))) >>> s;
		return x < 0 ? -m : m;
	endfunction

	function automatic longint sat(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint norm_comp(longint a, longint d);
		longint q;
		q = ((a < 0 ? -a : a) <<< 24) / d;
		return a < 0 ? -q : q;
	endfunction

	function automatic resp_t collide(pair_t p);
		longint p1x, p1y, p2x, p2y, v1x, v1y, v2x, v2y, dx, dy, rs, nx, ny, m, px, py, vi;
		longint cx, cy, ov;
		logic [63:0] d2, d, rem, bitv;
		resp_t r;
		p1x = p.p1x; p1y = p.p1y; p2x = p.p2x; p2y = p.p2y;
		v1x = p.v1x; v1y = p.v1y; v2x = p.v2x; v2y = p.v2y;
		dx = p1x - p2x; dy = p1y - p2y;
		d2 = dx * dx + dy * dy;
		rs = longint'(p.r1) + longint'(p.r2);
		r.hit = 1'b0;
		if (d2 > 0 && d2 < rs * rs) begin
			rem = d2 << 16; d = 0; bitv = 64'd1 << 62;
			while (bitv > rem) bitv >>= 2;
			while (bitv != 0) begin
				if (rem >= d + bitv) begin
					rem -= d + bitv;
					d = (d >> 1) + bitv;
				end else
					d >>= 1;
				bitv >>= 2;
			end
			ov = (rs <<< 8) - longint'(d);
			nx = norm_comp(dx, d); ny = norm_comp(dy, d);
			m = (ov * longint'(gain_q)) >>> 16;
			px = rnd_half(m * nx, 24); py = rnd_half(m * ny, 24);
			r.hit = 1'b1;
			p1x = sat(p1x + px, 0, cpc_pkg::POS_MAX); p1y = sat(p1y + py, 0, cpc_pkg::POS_MAX);
			p2x = sat(p2x - px, 0, cpc_pkg::POS_MAX); p2y = sat(p2y - py, 0, cpc_pkg::POS_MAX);
			vi = (v2x - v1x) * nx + (v2y - v1y) * ny;
			if (vi >= 0) begin
				cx = rnd_half(vi * nx, 32); cy = rnd_half(vi * ny, 32);
				v1x = sat(v1x + cx, cpc_pkg::VEL_MIN, cpc_pkg::VEL_MAX);
				v1y = sat(v1y + cy, cpc_pkg::VEL_MIN, cpc_pkg::VEL_MAX);
				v2x = sat(v2x - cx, cpc_pkg::VEL_MIN, cpc_pkg::VEL_MAX);
				v2y = sat(v2y - cy, cpc_pkg::VEL_MIN, cpc_pkg::VEL_MAX);
			end
		end
		r.p1x = 18'(p1x); r.p1y = 18'(p1y); r.p2x = 18'(p2x); r.p2y = 18'(p2y);
		r.v1x = 20'(v1x); r.v1y = 20'(v1y); r.v2x = 20'(v2x); r.v2y = 20'(v2y);
		return r;
	endfunction

	task automatic report_mismatch(string what, longint e, longint g);
		errors++;
		$display("MISMATCH %s: expected %0d got %0d at %0t", what, e, g, $realtime);
	endtask

	// receiver: random stalls, forced hold-off when stall_left > 0
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 13);
	end

	always @(posedge clk) begin
		resp_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_resp.size() == 0)
				report_mismatch("unexpected item", 0, 1);
			else begin
				e = expected_resp.pop_front();
				if (got.hit !== e.hit) report_mismatch("hit", e.hit, got.hit);
				if (got.p1x !== e.p1x) report_mismatch("new_first_pos_x", e.p1x, got.p1x);
				if (got.p1y !== e.p1y) report_mismatch("new_first_pos_y", e.p1y, got.p1y);
				if (got.p2x !== e.p2x) report_mismatch("new_second_pos_x", e.p2x, got.p2x);
				if (got.p2y !== e.p2y) report_mismatch("new_second_pos_y", e.p2y, got.p2y);
				if (got.v1x !== e.v1x) report_mismatch("new_first_vel_x", e.v1x, got.v1x);
				if (got.v1y !== e.v1y) report_mismatch("new_first_vel_y", e.v1y, got.v1y);
				if (got.v2x !== e.v2x) report_mismatch("new_second_vel_x", e.v2x, got.v2x);
				if (got.v2y !== e.v2y) report_mismatch("new_second_vel_y", e.v2y, got.v2y);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// valid stays high into the next call; drain or an idle gap drops it
	task automatic send_pair(pair_t p);
		while (!no_idle && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		drv <= p;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_resp.push_back(collide(p));
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_resp.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_gain(logic [15:0] g);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= g;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		gain_q = g;
	endtask

	function automatic pair_t rand_pair(bit touching);
		pair_t p;
		int ang;
		p.p1x = 18'($urandom); p.p1y = 18'($urandom);
		p.p2x = 18'($urandom); p.p2y = 18'($urandom);
		p.v1x = 20'($urandom); p.v1y = 20'($urandom);
		p.v2x = 20'($urandom); p.v2y = 20'($urandom);
		p.r1 = 16'($urandom); p.r2 = 16'($urandom);
		if (touching) begin
			p.p2x = 18'(sat(longint'(p.p1x) + $signed($urandom_range(0, 16384)) - 8192,
				0, cpc_pkg::POS_MAX));
			p.p2y = 18'(sat(longint'(p.p1y) + $signed($urandom_range(0, 16384)) - 8192,
				0, cpc_pkg::POS_MAX));
			ang = $urandom_range(3);
			if (ang == 0) begin
				p.r1 = 16'($urandom_range(0, 6000)); p.r2 = 16'($urandom_range(0, 6000));
			end
			if (ang == 1) begin
				p.v1x = 20'($signed($urandom_range(0, 4000)) - 2000);
				p.v2x = 20'($signed($urandom_range(0, 4000)) - 2000);
			end
		end
		return p;
	endfunction

	task automatic test_directed();
		pair_t p;
		p = '0; send_pair(p);
		p.r1 = 16'hFFFF; p.r2 = 16'hFFFF; send_pair(p);
		p = '0; p.p1x = 18'h3FFFF; p.p1y = 18'h3FFFF; p.r1 = 16'hFFFF; p.r2 = 16'hFFFF;
		p.v1x = 20'sh7FFFF; p.v1y = -20'sh80000; p.v2x = -20'sh80000; p.v2y = 20'sh7FFFF;
		send_pair(p);
		p = '0; p.p1x = 18'd1000; p.p2x = 18'd1100; p.r1 = 16'd100; p.r2 = 16'd0;
		send_pair(p);
		p.r1 = 16'd60; p.r2 = 16'd40; send_pair(p);
		p.r1 = 16'd60; p.r2 = 16'd41; p.v1x = 20'sd500; p.v2x = -20'sd500; send_pair(p);
		p.v1x = -20'sd500; p.v2x = 20'sd500; send_pair(p);
		p = '0; p.p1x = 18'd1; p.p2x = 18'd0; p.r1 = 16'hFFFF; p.r2 = 16'hFFFF;
		p.v1x = 20'sh7FFFF; p.v2x = -20'sh80000; send_pair(p);
		p = '0; p.p1x = 18'h3FFFF; p.p2x = 18'h3FFFE; p.p2y = 18'd3; p.r1 = 16'hFFFF;
		p.r2 = 16'hFFFF; p.v1x = -20'sh80000; p.v2x = 20'sh7FFFF; p.v2y = -20'sh80000;
		send_pair(p);
		p = '0; p.p1x = 18'd5000; p.p1y = 18'd5000; p.p2x = 18'd5300; p.p2y = 18'd4700;
		p.r1 = 16'd300; p.r2 = 16'd300; p.v1x = 20'sd1000; p.v1y = -20'sd300;
		p.v2x = -20'sd700; p.v2y = 20'sd900; send_pair(p);
		p.p1x = 18'h2AAAA; p.p2x = 18'h15555; p.p1y = 18'h15555; p.p2y = 18'h2AAAA;
		p.v1x = 20'shAAAAA; p.v2x = 20'sh55555; p.r1 = 16'hAAAA; p.r2 = 16'h5555;
		send_pair(p);
	endtask

	task automatic test_random(int n);
		repeat (n) send_pair(rand_pair($urandom_range(99) < 80));
	endtask

	task automatic test_backpressure();
		fork
			stall_left = 300;
			test_random(120);
		join
	endtask

	task automatic test_no_idle();
		no_idle = 1;
		test_random(200);
		no_idle = 0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_directed();
		test_random(300);
		write_gain(16'h0000);
		test_directed();
		test_random(150);
		write_gain(16'hFFFF);
		test_directed();
		test_random(150);
		test_backpressure();
		write_gain(16'h8000);
		test_no_idle();
		test_random(300);
		write_gain(cpc_pkg::GAIN_RST);
		test_random(200);
		drain();
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire
